### rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, round constants and the rotate and schedule functions of the
// SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } back_state_e;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] sched_next(input logic [31:0] w [16]);
    logic [31:0] s0;
    logic [31:0] s1;
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    sched_next = w[0] + s0 + w[9] + s1;
  endfunction

endpackage

### rtl/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream with a queued intake and a round-serial core.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o): one beat per item; action 0 absorbs
// data_byte_i, action 1 pads the message and requests the digest.
// Output channel (out_valid_o/out_ready_i): eight beats per finish, word 0
// first, last_word_o on word 7.
// Each absorbed byte is written into the block; every 64th byte also runs
// 64 rounds on the single round unit plus an add step. A finish pads byte
// by byte, runs one or two compressions, then hands out the digest words
// at one per cycle while out_ready_i is high.
// A four-entry queue keeps taking beats while the core compresses or while
// the receiver stalls; in_ready_o drops only when the queue is full.
// Reset restores the initial hash values and clears the byte and bit counts.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha_pkg::*;

  item_t in_item, q_item;
  logic  q_full, q_empty, q_pop;

  assign in_item    = '{action: action_i, data_byte: data_byte_i};
  assign in_ready_o = !q_full;

  sha_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (in_valid_i),
    .push_item_i (in_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_item_o  (q_item),
    .empty_o     (q_empty)
  );

  sha_core u_core (
    .clk_i,
    .rst_ni,
    .item_valid_i (!q_empty),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .out_valid_o,
    .out_ready_i,
    .digest_word_o,
    .word_index_o,
    .last_word_o
  );

endmodule

### rtl/sha_queue.sv
// ----------------------------------------------------------------------------
// sha_queue
// Short item queue between the intake front and the compression back end.
// ----------------------------------------------------------------------------
module sha_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sha_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output sha_pkg::item_t pop_item_o,
  output logic           empty_o
);
  import sha_pkg::*;

  localparam int unsigned Aw = $clog2(QueueDepth);

  item_t       mem_q [QueueDepth];
  logic [Aw-1:0] wr_q, rd_q;
  logic [Aw:0]   cnt_q;

  assign full_o     = (cnt_q == (Aw+1)'(QueueDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_item_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wr_q <= wr_q + 1'b1;
      if (pop_i && !empty_o) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push_i && !full_o) - (Aw+1)'(pop_i && !empty_o);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |=> (cnt_q <= (Aw+1)'(QueueDepth)))
    else $error("queue count overflow");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[Aw-1:0] == wr_q - rd_q))
    else $error("queue pointers disagree with count");
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o && pop_i && !push_i) |=> empty_o)
    else $error("pop from empty queue moved state");
`endif

endmodule

### rtl/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core
// Back end: fills the block, pads on finish, runs one round per cycle and
// hands out the eight digest words.
// ----------------------------------------------------------------------------
module sha_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  sha_pkg::item_t item_i,
  output logic           item_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [31:0]    digest_word_o,
  output logic [2:0]     word_index_o,
  output logic           last_word_o
);
  import sha_pkg::*;

  back_state_e state_q, state_d;
  logic [31:0] w_q [16];
  logic [31:0] h_q [8];
  logic [31:0] s_q [8];
  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic [63:0] len_q;
  logic [5:0]  rnd_q;
  logic [2:0]  widx_q;
  logic        fin_q;
  logic        pad_first_q;
  logic        pad_active_q;
  logic        len_here_q;

  logic        put;
  logic [7:0]  put_byte;
  logic [7:0]  pad_byte;
  logic [31:0] t1, t2;

  always_comb begin
    if (pad_first_q) pad_byte = PadByte;
    else if (len_here_q && fill_q >= LenStart) begin
      pad_byte = len_q[8'(63 - 8*int'(fill_q[2:0])) -: 8];
    end else pad_byte = '0;
  end

  always_comb begin
    t1 = s_q[7] + (rotr(s_q[4], 6) ^ rotr(s_q[4], 11) ^ rotr(s_q[4], 25))
       + ((s_q[4] & s_q[5]) ^ (~s_q[4] & s_q[6])) + RoundK[rnd_q] + w_q[0];
    t2 = (rotr(s_q[0], 2) ^ rotr(s_q[0], 13) ^ rotr(s_q[0], 22))
       + ((s_q[0] & s_q[1]) ^ (s_q[0] & s_q[2]) ^ (s_q[1] & s_q[2]));
  end

  always_comb begin
    state_d    = state_q;
    item_pop_o = 1'b0;
    put        = 1'b0;
    put_byte   = item_i.data_byte;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          if (item_i.action) begin
            state_d = ST_PAD;
          end else begin
            put = 1'b1;
            if (fill_q == 6'd63) state_d = ST_ROUND;
          end
        end
      end
      ST_PAD: begin
        put      = 1'b1;
        put_byte = pad_byte;
        if (fill_q == 6'd63) state_d = ST_ROUND;
      end
      ST_ROUND: if (rnd_q == 6'd63) state_d = ST_ADD;
      ST_ADD: begin
        if (fin_q) state_d = ST_EMIT;
        else if (pad_active_q) state_d = ST_PAD;
        else state_d = ST_IDLE;
      end
      ST_EMIT:  if (out_ready_i && widx_q == 3'd7) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o   = (state_q == ST_EMIT);
  assign digest_word_o = h_q[widx_q];
  assign word_index_o  = widx_q;
  assign last_word_o   = (widx_q == 3'd7);

  always_ff @(posedge clk_i) begin
    if (put) begin
      w_q[fill_q[5:2]] <= {w_q[fill_q[5:2]][23:0], put_byte};
    end
    if (state_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= sched_next(w_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      h_q          <= InitHash;
      s_q          <= InitHash;
      fill_q       <= '0;
      bits_q       <= '0;
      len_q        <= '0;
      rnd_q        <= '0;
      widx_q       <= '0;
      fin_q        <= 1'b0;
      pad_first_q  <= 1'b0;
      pad_active_q <= 1'b0;
      len_here_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE && item_valid_i && item_i.action) begin
        len_q        <= bits_q;
        pad_first_q  <= 1'b1;
        pad_active_q <= 1'b1;
        len_here_q   <= (fill_q < LenStart);
      end
      if (state_q == ST_IDLE && item_valid_i && !item_i.action) bits_q <= bits_q + 64'd8;
      if (put) begin
        fill_q <= fill_q + 1'b1;
        if (state_q == ST_PAD) pad_first_q <= 1'b0;
        if (state_q == ST_PAD && fill_q == 6'd63) begin
          if (len_here_q) fin_q <= 1'b1;
          else len_here_q <= 1'b1;
        end
        if (fill_q == 6'd63) s_q <= h_q;
      end
      if (state_q == ST_ROUND) begin
        rnd_q  <= rnd_q + 1'b1;
        s_q[0] <= t1 + t2;
        s_q[1] <= s_q[0];
        s_q[2] <= s_q[1];
        s_q[3] <= s_q[2];
        s_q[4] <= s_q[3] + t1;
        s_q[5] <= s_q[4];
        s_q[6] <= s_q[5];
        s_q[7] <= s_q[6];
      end
      if (state_q == ST_ADD) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + s_q[i];
        if (fin_q) pad_active_q <= 1'b0;
      end
      if (state_q == ST_EMIT && out_ready_i) begin
        widx_q <= widx_q + 1'b1;
        if (widx_q == 3'd7) begin
          h_q    <= InitHash;
          fin_q  <= 1'b0;
          bits_q <= '0;
          fill_q <= '0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_emit_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(widx_q)))
    else $error("digest word moved under stall");
  a_round_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (fill_q == '0))
    else $error("block not full during rounds");
  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_word_o) |=> (bits_q == '0))
    else $error("counter not cleared after digest");
`endif

endmodule
